>>> rtl/fplru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fplru_pkg
// Types and constants shared by the frame-pinned LRU cache policy modules.
// ----------------------------------------------------------------------------
package fplru_pkg;

    // operation codes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_ACQUIRE = 2'd1;
    localparam logic [1:0] OP_RESEED  = 2'd2;

    localparam int unsigned EIU_W = 5;
    localparam logic [EIU_W-1:0] EIU_RESET = 5'd16;

    localparam int unsigned SLOT_W  = 32;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned SEED_W  = 64;
    localparam int unsigned INDEX_W = 4;

    // one stored cache entry (valid bit held separately)
    typedef struct packed {
        logic               layer;
        logic [SLOT_W-1:0]  slot;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // running victim choice during a scan
    typedef struct packed {
        logic               have;
        logic               valid;
        logic [STAMP_W-1:0] stamp;
    } t_pick;

    // per-entry decision from the compare unit
    typedef struct packed {
        logic hit;
        logic take;
    } t_scan_dec;

endpackage
`default_nettype wire

>>> rtl/fplru_scan_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fplru_scan_unit
// Shared compare unit: judges one entry per cycle against the requested tag,
// the current frame and the victim picked so far.
// ----------------------------------------------------------------------------
module fplru_scan_unit (
    input  wire fplru_pkg::t_entry             i_entry,
    input  wire logic                          i_entry_valid,
    input  wire logic                          i_layer,
    input  wire logic [fplru_pkg::SLOT_W-1:0]  i_slot,
    input  wire logic [fplru_pkg::STAMP_W-1:0] i_frame,
    input  wire fplru_pkg::t_pick              i_pick,
    output fplru_pkg::t_scan_dec               o_dec
);
    import fplru_pkg::*;

    logic w_match;
    logic w_pinned;
    logic w_older;

    // tag match, pin check and stamp age compare
    assign w_match  = i_entry_valid && (i_entry.layer == i_layer) && (i_entry.slot == i_slot);
    assign w_pinned = i_entry_valid && (i_entry.stamp == i_frame);
    assign w_older  = i_pick.valid && (i_entry.stamp < i_pick.stamp);

    always_comb begin
        o_dec.hit  = w_match;
        o_dec.take = !w_match && !w_pinned && (!i_pick.have || !i_entry_valid || w_older);
    end

endmodule
`default_nettype wire

>>> rtl/frame_pinned_lru_cache_policy.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_pinned_lru_cache_policy
// Fully associative tag cache with LRU replacement; entries used in the
// current frame are pinned against eviction.
// ----------------------------------------------------------------------------
// Usage: an item is taken when i_start is high and o_busy is low. Frame tick,
// reseed and unused codes answer in the next cycle. An acquire walks the
// first N = min(entries_in_use, ENTRIES) entries through one compare unit,
// one entry per cycle, reading the entry memory through its single registered
// read port; the walk ends early on a hit, and when N is zero the acquire
// answers in the next cycle without a walk. o_busy is high while the walk is
// on. Each result shows for one cycle with o_done; the receiver cannot stall,
// and a new item may be started in the cycle a result is shown.
// ----------------------------------------------------------------------------
module frame_pinned_lru_cache_policy #(
    parameter int unsigned ENTRIES = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    output      logic                           o_busy,
    input  wire logic [1:0]                     i_operation,
    input  wire logic                           i_layer,
    input  wire logic signed [fplru_pkg::SLOT_W-1:0] i_slot,
    input  wire logic [fplru_pkg::SEED_W-1:0]   i_new_seed,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [fplru_pkg::EIU_W-1:0]    i_cfg_wr_data,
    output      logic                           o_done,
    output      logic                           o_found,
    output      logic                           o_hit,
    output      logic [fplru_pkg::INDEX_W-1:0]  o_entry_index,
    output      logic                           o_flushed
);
    import fplru_pkg::*;

    localparam int unsigned IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW  = $clog2(ENTRIES + 1);
    localparam int unsigned LW  = (CW > EIU_W) ? CW : EIU_W;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state r_state, n_state;

    logic [EIU_W-1:0]   r_eiu;
    logic [STAMP_W-1:0] r_frame, n_frame;
    logic [SEED_W-1:0]  r_seed, n_seed;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [IW-1:0]      r_idx, n_idx;
    logic               r_layer, n_layer;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    t_pick              r_pick, n_pick;
    logic [IW-1:0]      r_pick_idx, n_pick_idx;

    logic               n_done, n_found, n_hit, n_flushed;
    logic [INDEX_W-1:0] n_entry_index;

    // entry memory
    t_entry             r_mem [ENTRIES];
    t_entry             r_rd_data;
    logic [IW-1:0]      w_rd_addr;
    logic               w_wr_en;
    logic [IW-1:0]      w_wr_addr;
    t_entry             w_wr_data;

    logic               w_accept;
    logic [LW-1:0]      w_eiu_ext;
    logic [LW-1:0]      w_limit;
    logic               w_last;
    logic               w_cur_valid;
    t_scan_dec          w_dec;

    // effective scan limit
    assign w_eiu_ext = LW'(r_eiu);
    assign w_limit   = (w_eiu_ext > LW'(ENTRIES)) ? LW'(ENTRIES) : w_eiu_ext;

    assign w_accept    = i_start && (r_state == S_IDLE);
    assign w_last      = (LW'(r_idx) + LW'(1)) == w_limit;
    assign w_cur_valid = r_valid[r_idx];
    assign w_rd_addr   = (r_state == S_IDLE) ? '0 : r_idx + IW'(1);

    // compare unit
    fplru_scan_unit u_scan (
        .i_entry       (r_rd_data),
        .i_entry_valid (w_cur_valid),
        .i_layer       (r_layer),
        .i_slot        (r_slot),
        .i_frame       (r_frame),
        .i_pick        (r_pick),
        .o_dec         (w_dec)
    );

    // sequencer next state
    always_comb begin
        n_state       = r_state;
        n_frame       = r_frame;
        n_seed        = r_seed;
        n_valid       = r_valid;
        n_idx         = r_idx;
        n_layer       = r_layer;
        n_slot        = r_slot;
        n_pick        = r_pick;
        n_pick_idx    = r_pick_idx;
        n_done        = 1'b0;
        n_found       = 1'b0;
        n_hit         = 1'b0;
        n_flushed     = 1'b0;
        n_entry_index = '0;
        w_wr_en       = 1'b0;
        w_wr_addr     = r_idx;
        w_wr_data.layer = r_layer;
        w_wr_data.slot  = r_slot;
        w_wr_data.stamp = r_frame;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_layer = i_layer;
                    n_slot  = i_slot;
                    n_idx   = '0;
                    n_pick  = '0;
                    n_pick_idx = '0;
                    case (i_operation)
                        OP_TICK: begin
                            n_frame = r_frame + STAMP_W'(1);
                            n_done  = 1'b1;
                        end
                        OP_ACQUIRE: begin
                            if (w_limit == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_RESEED: begin
                            n_done = 1'b1;
                            if (i_new_seed != r_seed) begin
                                n_seed    = i_new_seed;
                                n_valid   = '0;
                                n_flushed = 1'b1;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_idx = r_idx + IW'(1);
                if (w_dec.take) begin
                    n_pick.have  = 1'b1;
                    n_pick.valid = w_cur_valid;
                    n_pick.stamp = r_rd_data.stamp;
                    n_pick_idx   = r_idx;
                end
                if (w_dec.hit) begin
                    // restamp the matching entry
                    w_wr_en       = 1'b1;
                    w_wr_addr     = r_idx;
                    n_done        = 1'b1;
                    n_found       = 1'b1;
                    n_hit         = 1'b1;
                    n_entry_index = INDEX_W'(r_idx);
                    n_state       = S_IDLE;
                end else if (w_last) begin
                    // claim the victim, if any
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (n_pick.have) begin
                        w_wr_en              = 1'b1;
                        w_wr_addr            = n_pick_idx;
                        n_valid[n_pick_idx]  = 1'b1;
                        n_found              = 1'b1;
                        n_entry_index        = INDEX_W'(n_pick_idx);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_eiu         <= EIU_RESET;
            r_frame       <= '0;
            r_seed        <= '0;
            r_valid       <= '0;
            o_done        <= 1'b0;
            o_found       <= 1'b0;
            o_hit         <= 1'b0;
            o_entry_index <= '0;
            o_flushed     <= 1'b0;
        end else begin
            r_state       <= n_state;
            if (i_cfg_wr_en) begin
                r_eiu <= i_cfg_wr_data;
            end
            r_frame       <= n_frame;
            r_seed        <= n_seed;
            r_valid       <= n_valid;
            o_done        <= n_done;
            o_found       <= n_found;
            o_hit         <= n_hit;
            o_entry_index <= n_entry_index;
            o_flushed     <= n_flushed;
        end
        r_idx      <= n_idx;
        r_layer    <= n_layer;
        r_slot     <= n_slot;
        r_pick     <= n_pick;
        r_pick_idx <= n_pick_idx;
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    assign o_busy = (r_state == S_SCAN);

`ifndef SYNTH
    // a hit is always a found entry
    a_hit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_hit |-> o_found)
        else $error("hit reported without found");

    // a flush never reports an entry
    a_flush_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_flushed |-> o_done && !o_found && !o_hit)
        else $error("flush mixed with acquire result");

    // an acquire with entries in use starts a scan
    a_acq_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_operation == OP_ACQUIRE) && (w_limit != '0) |=> o_busy)
        else $error("acquire did not start scan");

    // the scan stays inside the entries in use
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (LW'(r_idx) < w_limit))
        else $error("scan index beyond limit");

    // end of scan always delivers a result
    a_scan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> o_done)
        else $error("scan ended without result");
`endif

endmodule
`default_nettype wire

>>> tb/frame_pinned_lru_cache_policy_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_pinned_lru_cache_policy_tb
// Self-checking bench for the frame-pinned LRU tag cache. A short directed
// table covers reset state, tag extremes, flushes, full pinning, empty and
// oversized entry counts; random phases then sweep the entry count while
// items flow in bursts. Each result is matched against a shadow copy of the
// cache state kept in the bench, or against the outcome a directed row gives.
// ----------------------------------------------------------------------------
module frame_pinned_lru_cache_policy_tb;
    import fplru_pkg::*;

    localparam int unsigned TB_ENTRIES = 16;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned ITEMS_PER_PHASE = 95;
    localparam int unsigned N_PHASES = 9;
    localparam int unsigned POOL_MAX = 24;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // one result of the block
    typedef struct packed {
        logic               found;
        logic               hit;
        logic [INDEX_W-1:0] index;
        logic               flushed;
    } t_outcome;

    localparam t_outcome NONE       = '0;
    localparam t_outcome FLUSH_ONLY = {1'b0, 1'b0, 4'd0, 1'b1};
    localparam t_outcome MISS_LAST  = {1'b1, 1'b0, 4'(TB_ENTRIES - 1), 1'b0};
    localparam t_outcome HIT_LAST   = {1'b1, 1'b1, 4'(TB_ENTRIES - 1), 1'b0};
    localparam logic [SEED_W-1:0] SEED_ONES = '1;

    // one row of the directed table: an entry-count write or an item
    typedef struct packed {
        bit                 is_cfg;
        logic [EIU_W-1:0]   cfg_value;
        logic [1:0]         op;
        logic               layer;
        logic [SLOT_W-1:0]  slot;
        logic [SEED_W-1:0]  seed;
        bit                 typed;
        t_outcome           want;
    } t_stim_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_start = 1'b0;
    logic [1:0]              i_operation = OP_TICK;
    logic                    i_layer = 1'b0;
    logic signed [SLOT_W-1:0] i_slot = '0;
    logic [SEED_W-1:0]       i_new_seed = '0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [EIU_W-1:0]        i_cfg_wr_data = '0;
    logic                    o_busy;
    logic                    o_done;
    logic                    o_found;
    logic                    o_hit;
    logic [INDEX_W-1:0]      o_entry_index;
    logic                    o_flushed;

    // shadow cache state
    logic               sh_valid [TB_ENTRIES];
    logic               sh_layer [TB_ENTRIES];
    logic [SLOT_W-1:0]  sh_slot  [TB_ENTRIES];
    logic [STAMP_W-1:0] sh_stamp [TB_ENTRIES];
    logic [STAMP_W-1:0] sh_frame;
    logic [SEED_W-1:0]  sh_seed;
    logic [EIU_W-1:0]   sh_in_use;

    t_outcome  pending_outcomes[$];
    t_stim_row directed_rows[$];
    int unsigned fail_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned burst_left = 0;

    frame_pinned_lru_cache_policy #(
        .ENTRIES (TB_ENTRIES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_operation   (i_operation),
        .i_layer       (i_layer),
        .i_slot        (i_slot),
        .i_new_seed    (i_new_seed),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_done        (o_done),
        .o_found       (o_found),
        .o_hit         (o_hit),
        .o_entry_index (o_entry_index),
        .o_flushed     (o_flushed)
    );

    always #5 i_clk = ~i_clk;

    // Apply one item to the shadow cache and return what the block must answer.
    function automatic t_outcome cache_decide(logic [1:0] op, logic layer,
                                              logic [SLOT_W-1:0] slot,
                                              logic [SEED_W-1:0] seed);
        t_outcome    r;
        int unsigned lim;
        int unsigned pick;
        logic        have;
        logic        done;
        logic        pinned;
        r = NONE;
        case (op)
            OP_TICK: begin
                sh_frame = sh_frame + STAMP_W'(1);
            end
            OP_ACQUIRE: begin
                lim  = (sh_in_use > TB_ENTRIES) ? TB_ENTRIES : sh_in_use;
                have = 1'b0;
                done = 1'b0;
                pick = 0;
                for (int i = 0; i < lim && !done; i++) begin
                    pinned = sh_valid[i] && sh_stamp[i] == sh_frame;
                    if (sh_valid[i] && sh_layer[i] == layer && sh_slot[i] == slot) begin
                        sh_stamp[i] = sh_frame;
                        r.found = 1'b1;
                        r.hit   = 1'b1;
                        r.index = INDEX_W'(i);
                        done    = 1'b1;
                    end else if (!pinned && (!have || !sh_valid[i] ||
                             (sh_valid[pick] && sh_stamp[i] < sh_stamp[pick]))) begin
                        // last invalid wins; among valid, lowest index of oldest stamp
                        have = 1'b1;
                        pick = i;
                    end
                end
                if (!done && have) begin
                    sh_valid[pick] = 1'b1;
                    sh_layer[pick] = layer;
                    sh_slot[pick]  = slot;
                    sh_stamp[pick] = sh_frame;
                    r.found = 1'b1;
                    r.index = INDEX_W'(pick);
                end
            end
            OP_RESEED: begin
                if (seed != sh_seed) begin
                    sh_seed = seed;
                    for (int i = 0; i < TB_ENTRIES; i++) sh_valid[i] = 1'b0;
                    r.flushed = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void add_item(logic [1:0] op, logic layer, logic [SLOT_W-1:0] slot,
                                     logic [SEED_W-1:0] seed, bit typed, t_outcome want);
        directed_rows.push_back({1'b0, EIU_W'(0), op, layer, slot, seed, typed, want});
    endfunction

    function automatic void add_cfg(logic [EIU_W-1:0] value);
        directed_rows.push_back({1'b1, value, OP_TICK, 1'b0, SLOT_W'(0), SEED_W'(0),
                                 1'b0, NONE});
    endfunction

    // Present one item, hold it until taken, then log the expected outcome.
    task automatic send_item(input logic [1:0] op, input logic layer,
                             input logic [SLOT_W-1:0] slot, input logic [SEED_W-1:0] seed,
                             input bit typed, input t_outcome typed_want);
        t_outcome want;
        i_start     <= 1'b1;
        i_operation <= op;
        i_layer     <= layer;
        i_slot      <= slot;
        i_new_seed  <= seed;
        do @(posedge i_clk); while (o_busy);
        want = cache_decide(op, layer, slot, seed);
        pending_outcomes.push_back(typed ? typed_want : want);
    endtask

    // Sender bursts: random-length runs of back-to-back items, random gaps.
    task automatic idle_between();
        if (burst_left == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        while (pending_outcomes.size() != 0 || o_busy) @(posedge i_clk);
    endtask

    // Entry count is only changed while the block is idle.
    task automatic set_entries_in_use(input logic [EIU_W-1:0] value);
        i_start <= 1'b0;
        wait_drained();
        repeat (2) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        sh_in_use = value;
        i_cfg_wr_en <= 1'b0;
    endtask

    // Result check and watchdog
    always @(posedge i_clk) begin : result_check
        t_outcome got;
        t_outcome want;
        got = {o_found, o_hit, o_entry_index, o_flushed};
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_outcomes.size() == 0) begin
                    if (fail_count < 10)
                        $display({"%0t: result with nothing expected: ",
                                  "found=%b hit=%b idx=%0d fl=%b"},
                                 $realtime, got.found, got.hit, got.index, got.flushed);
                    fail_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (got.found !== want.found || got.hit !== want.hit ||
                        got.index !== want.index || got.flushed !== want.flushed) begin
                        if (fail_count < 10)
                            $display({"%0t: mismatch exp found=%b hit=%b idx=%0d fl=%b",
                                      " / got found=%b hit=%b idx=%0d fl=%b"},
                                     $realtime, want.found, want.hit, want.index,
                                     want.flushed, got.found, got.hit, got.index,
                                     got.flushed);
                        fail_count++;
                    end
                end
            end
            if (o_done || (i_start && !o_busy)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("** frame_pinned_lru_cache_policy: FAILED **");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_stim_row         row;
        logic [SLOT_W-1:0] slot_pool [POOL_MAX];
        int unsigned       phase_eiu [N_PHASES];
        int unsigned       tick_pct;
        int unsigned       pool_n;
        int unsigned       count;
        int unsigned       roll;
        logic [1:0]        op;
        logic              layer;
        logic [SLOT_W-1:0] slot;
        logic [SEED_W-1:0] seed;

        // shadow state after reset
        for (int i = 0; i < TB_ENTRIES; i++) begin
            sh_valid[i] = 1'b0;
            sh_layer[i] = 1'b0;
            sh_slot[i]  = '0;
            sh_stamp[i] = '0;
        end
        sh_frame  = '0;
        sh_seed   = '0;
        sh_in_use = EIU_RESET;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: fresh cache fills from the top entry, tag extremes
        add_item(OP_ACQUIRE, 1'b0, 32'h0000_0000, '0, 1'b1, MISS_LAST);
        add_item(OP_ACQUIRE, 1'b0, 32'h0000_0000, '0, 1'b1, HIT_LAST);
        add_item(OP_ACQUIRE, 1'b1, 32'h0000_0000, '0, 1'b0, NONE);
        add_item(OP_ACQUIRE, 1'b0, 32'h7FFF_FFFF, '0, 1'b0, NONE);
        add_item(OP_ACQUIRE, 1'b1, 32'h8000_0000, '0, 1'b0, NONE);
        add_item(OP_ACQUIRE, 1'b0, 32'hFFFF_FFFF, '0, 1'b0, NONE);
        add_item(OP_ACQUIRE, 1'b1, 32'h8000_0000, '0, 1'b0, NONE);
        // unused code does nothing, tick answers all zero
        add_item(OP_UNUSED, 1'b1, 32'hFFFF_FFFF, SEED_ONES, 1'b1, NONE);
        add_item(OP_TICK, 1'b0, 32'h0000_0000, '0, 1'b1, NONE);
        add_item(OP_ACQUIRE, 1'b0, 32'h0000_0000, '0, 1'b0, NONE);
        // same seed keeps the cache, a new one flushes it
        add_item(OP_RESEED, 1'b0, 32'h0000_0000, '0, 1'b1, NONE);
        add_item(OP_RESEED, 1'b0, 32'h0000_0000, SEED_ONES, 1'b1, FLUSH_ONLY);
        add_item(OP_RESEED, 1'b1, 32'hFFFF_FFFF, SEED_ONES, 1'b1, NONE);
        add_item(OP_ACQUIRE, 1'b1, 32'h7FFF_FFFF, '0, 1'b1, MISS_LAST);
        // two entries: the third distinct tag finds everything pinned
        add_cfg(5'd2);
        add_item(OP_ACQUIRE, 1'b0, 32'd5, '0, 1'b0, NONE);
        add_item(OP_ACQUIRE, 1'b0, 32'd6, '0, 1'b0, NONE);
        add_item(OP_ACQUIRE, 1'b0, 32'd7, '0, 1'b1, NONE);
        add_item(OP_TICK, 1'b0, 32'd0, '0, 1'b1, NONE);
        add_item(OP_ACQUIRE, 1'b0, 32'd7, '0, 1'b0, NONE);
        // no entries in use
        add_cfg(5'd0);
        add_item(OP_ACQUIRE, 1'b1, 32'd1, '0, 1'b1, NONE);
        // oversized counts act as the full cache
        add_cfg(5'd31);
        add_item(OP_ACQUIRE, 1'b0, 32'h7FFF_FFFF, '0, 1'b0, NONE);
        add_cfg(5'd17);
        add_item(OP_ACQUIRE, 1'b1, 32'h1234_5678, '0, 1'b0, NONE);

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.is_cfg) begin
                set_entries_in_use(row.cfg_value);
            end else begin
                send_item(row.op, row.layer, row.slot, row.seed, row.typed, row.want);
                idle_between();
            end
        end

        // random phases over a sweep of entry counts
        phase_eiu = '{16, 4, 1, 31, 0, 0, 17, 8, 0};
        phase_eiu[5] = $urandom_range(2, 15);
        phase_eiu[8] = $urandom_range(0, 31);
        slot_pool[0] = 32'h0000_0000;
        slot_pool[1] = 32'hFFFF_FFFF;
        slot_pool[2] = 32'h7FFF_FFFF;
        slot_pool[3] = 32'h8000_0000;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            set_entries_in_use(EIU_W'(phase_eiu[ph]));
            tick_pct = $urandom_range(3, 35);
            pool_n   = $urandom_range(4, POOL_MAX);
            for (int k = 4; k < POOL_MAX; k++) slot_pool[k] = $urandom;
            count = 0;
            while (count < ITEMS_PER_PHASE) begin
                roll  = $urandom_range(0, 99);
                layer = 1'($urandom_range(0, 1));
                slot  = $urandom;
                seed  = {$urandom, $urandom};
                if (roll < 3) begin
                    op = OP_UNUSED;
                end else if (roll < 7) begin
                    // mostly repeat the stored seed so flushes stay occasional
                    op = OP_RESEED;
                    case ($urandom_range(0, 3))
                        0, 1: seed = sh_seed;
                        2:    seed = $urandom_range(0, 1) ? SEED_ONES : '0;
                        default: begin
                        end
                    endcase
                end else if (roll < 7 + tick_pct) begin
                    op = OP_TICK;
                end else begin
                    // small tag pool per phase gives hits, pins and evictions
                    op = OP_ACQUIRE;
                    if ($urandom_range(0, 99) < 85)
                        slot = slot_pool[$urandom_range(0, pool_n - 1)];
                end
                send_item(op, layer, slot, seed, 1'b0, NONE);
                if (op != OP_UNUSED) count++;
                idle_between();
            end
        end

        // drain and let any stray strobe show up
        i_start <= 1'b0;
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("** frame_pinned_lru_cache_policy: PASSED **");
        else
            $display("** frame_pinned_lru_cache_policy: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
rtl/fplru_pkg.sv
rtl/fplru_scan_unit.sv
rtl/frame_pinned_lru_cache_policy.sv
tb/frame_pinned_lru_cache_policy_tb.sv
